// ----- rtl/core/pns_pkg.sv -----
// ----------------------------------------------------------------------------
// pns_pkg
// Shared widths, constants and types of the path norm statistics block.
// ----------------------------------------------------------------------------
package pns_pkg;

    localparam int COORD_W    = 24;              // signed Q12.12 coordinate
    localparam int IN_DATA_W  = 3 * COORD_W;     // x, y, z
    localparam int MAG_W      = 24;              // element norm
    localparam int SEG_W      = 25;              // segment length
    localparam int MM_W       = 25;              // min/max trackers
    localparam int NSQ_W      = 48;              // sum of squares, element
    localparam int SSQ_W      = 50;              // sum of squares, segment
    localparam int ROOT_W     = 26;              // root register
    localparam int RAD_W      = 2 * ROOT_W;      // radicand fed to the root unit
    localparam int REM_W      = ROOT_W + 2;      // partial remainder
    localparam int SQ_CYC     = ROOT_W / 2;      // two root digits per cycle
    localparam int SQ_CNT_W   = $clog2(SQ_CYC);
    localparam int LEN_W      = 37;
    localparam int POS_W      = 12;
    localparam int TOT_W      = 13;
    localparam int MAX_POINTS = 4096;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int QDEPTH     = 2;
    localparam int OUT_W      = LEN_W + 2 * (MAG_W + POS_W) + TOT_W + 1;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    // work item handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] dz;
        logic               has_seg;
        logic               last;
    } t_job;

    // result item, first field in the highest bits
    typedef struct packed {
        logic               too_many;
        logic [TOT_W-1:0]   point_total;
        logic [POS_W-1:0]   greatest_pos;
        logic [MAG_W-1:0]   greatest_norm;
        logic [POS_W-1:0]   least_pos;
        logic [MAG_W-1:0]   least_norm;
        logic [LEN_W-1:0]   total_length;
    } t_result;

endpackage

// ----- rtl/core/path_norm_statistics.sv -----
// ----------------------------------------------------------------------------
// path_norm_statistics
// Per-element norm, min/max with first index and polyline length of a
// stream of 3D Q12.12 points; one summary result per path.
// ----------------------------------------------------------------------------
// Each element passes pop, multiply/accumulate, root start, the two-bit-per-cycle
//   root, done and commit; the back end takes a new element only after commit.
// A two-entry queue lets the input accept up to two elements ahead of the back end;
//   a last element waits in commit while the previous summary is not taken.
// Reset (i_rst_n low, synchronous) clears the queue, the path statistics
//   and the output valid flag; no clearing pass is needed.
module path_norm_statistics (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pns_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic                           s_axis_tlast,  // last_point
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // total_length, least_norm, least_pos, greatest_norm, greatest_pos,
    // point_total, too_many, zero fill
    output logic [pns_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pns_pkg::*;

    t_job    front_job;
    t_job    queue_job;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    t_result result;

    pns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (q_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    pns_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (q_empty)
    );

    pns_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (queue_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_W){1'b0}}, result};

endmodule

// ----- rtl/core/pns_sqrt.sv -----
// ----------------------------------------------------------------------------
// pns_sqrt
// Floor integer square root, digit by digit, two result bits per cycle.
// ----------------------------------------------------------------------------
module pns_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pns_pkg::RAD_W-1:0] i_rad,
    output logic [pns_pkg::ROOT_W-1:0] o_root,
    output logic                      o_done
);
    import pns_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_state;

    function automatic t_sq_state sq_step(input t_sq_state s, input logic [1:0] pair);
        logic [REM_W+1:0] t_rem;
        logic [REM_W+1:0] trial;
        t_sq_state        r;
        t_rem = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (t_rem >= trial) begin
            t_rem  = t_rem - trial;
            r.rem  = t_rem[REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t_rem[REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    t_sq_state           n_s1;
    t_sq_state           n_s2;

    always_comb begin
        n_s1 = sq_step('{rem: r_rem, root: r_root}, r_rad[RAD_W-1 -: 2]);
        n_s2 = sq_step(n_s1, r_rad[RAD_W-3 -: 2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-5:0], 4'b0000};
            r_rem  <= n_s2.rem;
            r_root <= n_s2.root;
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == SQ_CNT_W'(SQ_CYC - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ----- rtl/core/pns_fifo.sv -----
// ----------------------------------------------------------------------------
// pns_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pns_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pns_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output pns_pkg::t_job o_job,
    output logic          o_empty
);
    import pns_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W  = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [QC_W-1:0]  r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == QC_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_mem[r_wr] <= i_job;
                r_wr <= (r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/pns_front.sv -----
// ----------------------------------------------------------------------------
// pns_front
// Accepts elements, forms absolute components and deltas to the previous
// element, and marks the first element of each path.
// ----------------------------------------------------------------------------
module pns_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pns_pkg::IN_DATA_W-1:0] s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic                          s_axis_tlast,  // last_point
    input  logic                          i_full,
    output logic                          o_push,
    output pns_pkg::t_job                 o_job
);
    import pns_pkg::*;

    function automatic logic [COORD_W-1:0] abs_val(input logic [COORD_W:0] v);
        logic [COORD_W:0] m;
        m = v[COORD_W] ? (~v + 1'b1) : v;
        return m[COORD_W-1:0];
    endfunction

    logic [COORD_W-1:0] r_px;
    logic [COORD_W-1:0] r_py;
    logic [COORD_W-1:0] r_pz;
    logic               r_in_path;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [COORD_W:0]   ex;
    logic [COORD_W:0]   ey;
    logic [COORD_W:0]   ez;

    assign cx = s_axis_tdata[COORD_W-1:0];
    assign cy = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign cz = s_axis_tdata[3*COORD_W-1:2*COORD_W];

    // sign-extended to one extra bit so deltas cannot wrap
    assign ex = {cx[COORD_W-1], cx};
    assign ey = {cy[COORD_W-1], cy};
    assign ez = {cz[COORD_W-1], cz};

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

    always_comb begin
        o_job.ax      = abs_val(ex);
        o_job.ay      = abs_val(ey);
        o_job.az      = abs_val(ez);
        o_job.dx      = abs_val(ex - {r_px[COORD_W-1], r_px});
        o_job.dy      = abs_val(ey - {r_py[COORD_W-1], r_py});
        o_job.dz      = abs_val(ez - {r_pz[COORD_W-1], r_pz});
        o_job.has_seg = r_in_path;
        o_job.last    = s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_path <= 1'b0;
        end else if (o_push) begin
            r_px      <= cx;
            r_py      <= cy;
            r_pz      <= cz;
            r_in_path <= !s_axis_tlast;
        end
    end

endmodule

// ----- rtl/core/pns_back.sv -----
// ----------------------------------------------------------------------------
// pns_back
// Squares and sums components, takes both roots, updates the path
// statistics and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module pns_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  pns_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output pns_pkg::t_result o_result
);
    import pns_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQR,
        ST_ROOT,
        ST_COMMIT
    } t_state;

    t_state             r_state;
    t_job               r_item;
    logic [1:0]         r_step;
    logic [NSQ_W-1:0]   r_pn;
    logic [NSQ_W-1:0]   r_ps;
    logic [NSQ_W-1:0]   r_sn;
    logic [SSQ_W-1:0]   r_ss;
    logic               r_start;
    logic [CNT_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_len;
    logic [MM_W-1:0]    r_min;
    logic [IDX_W-1:0]   r_min_at;
    logic [MM_W-1:0]    r_max;
    logic [IDX_W-1:0]   r_max_at;
    logic               r_ovf;
    logic               r_out_valid;
    t_result            r_out;

    logic [COORD_W-1:0] a_sel;
    logic [COORD_W-1:0] d_sel;
    logic [ROOT_W-1:0]  norm_root;
    logic [ROOT_W-1:0]  seg_root;
    logic               norm_done;
    logic               seg_done;
    logic               out_free;

    logic [MAG_W-1:0]   norm;
    logic [SEG_W-1:0]   seg;
    logic [LEN_W:0]     len_sum;
    logic [LEN_W-1:0]   n_len;
    logic [IDX_W-1:0]   idx;
    logic               full_cnt;
    logic [CNT_W-1:0]   n_count;
    logic               n_ovf;
    logic [MM_W-1:0]    n_min;
    logic [IDX_W-1:0]   n_min_at;
    logic [MM_W-1:0]    n_max;
    logic [IDX_W-1:0]   n_max_at;
    t_result            n_res;

    pns_sqrt u_norm_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_rad   ({{(RAD_W - NSQ_W){1'b0}}, r_sn}),
        .o_root  (norm_root),
        .o_done  (norm_done)
    );

    pns_sqrt u_seg_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_rad   ({{(RAD_W - SSQ_W){1'b0}}, r_ss}),
        .o_root  (seg_root),
        .o_done  (seg_done)
    );

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        case (r_step)
            2'd0:    begin a_sel = r_item.ax; d_sel = r_item.dx; end
            2'd1:    begin a_sel = r_item.ay; d_sel = r_item.dy; end
            2'd2:    begin a_sel = r_item.az; d_sel = r_item.dz; end
            default: begin a_sel = '0;        d_sel = '0;        end
        endcase
    end

    // statistics update for the element in flight
    always_comb begin
        norm     = norm_root[MAG_W-1:0];
        seg      = seg_root[SEG_W-1:0];
        len_sum  = {1'b0, r_len} + (r_item.has_seg ? (LEN_W + 1)'(seg) : '0);
        n_len    = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
        full_cnt = (r_count >= CNT_W'(MAX_POINTS));
        idx      = full_cnt ? IDX_W'(MAX_POINTS - 1) : r_count[IDX_W-1:0];
        n_count  = full_cnt ? r_count : r_count + 1'b1;
        n_ovf    = r_ovf || full_cnt;
        n_min    = r_min;
        n_min_at = r_min_at;
        n_max    = r_max;
        n_max_at = r_max_at;
        if (MM_W'(norm) < r_min) begin
            n_min    = MM_W'(norm);
            n_min_at = idx;
        end
        if (MM_W'(norm) > r_max) begin
            n_max    = MM_W'(norm);
            n_max_at = idx;
        end
        n_res.total_length  = n_len;
        n_res.least_norm    = n_min[MAG_W-1:0];
        n_res.least_pos     = POS_W'(n_min_at);
        n_res.greatest_norm = n_max[MAG_W-1:0];
        n_res.greatest_pos  = POS_W'(n_max_at);
        n_res.point_total   = TOT_W'(n_count);
        n_res.too_many      = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_len       <= '0;
            r_min       <= '1;
            r_min_at    <= '0;
            r_max       <= '0;
            r_max_at    <= '0;
            r_ovf       <= 1'b0;
        end else begin
            // a summary loaded in commit keeps the valid flag up
            if (i_ready && !(r_state == ST_COMMIT && r_item.last)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_job;
                        r_step  <= '0;
                        r_sn    <= '0;
                        r_ss    <= '0;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    // product registered, summed in the next cycle
                    r_pn   <= a_sel * a_sel;
                    r_ps   <= d_sel * d_sel;
                    r_step <= r_step + 1'b1;
                    if (r_step != 2'd0) begin
                        r_sn <= r_sn + r_pn;
                        r_ss <= r_ss + SSQ_W'(r_ps);
                    end
                    if (r_step == 2'd3) begin
                        r_start <= 1'b1;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_start <= 1'b0;
                    // done flag is stale while start is still pending
                    if (!r_start && norm_done) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (!r_item.last || out_free) begin
                        r_state <= ST_IDLE;
                        if (r_item.last) begin
                            r_out       <= n_res;
                            r_out_valid <= 1'b1;
                            r_count     <= '0;
                            r_len       <= '0;
                            r_min       <= '1;
                            r_min_at    <= '0;
                            r_max       <= '0;
                            r_max_at    <= '0;
                            r_ovf       <= 1'b0;
                        end else begin
                            r_count  <= n_count;
                            r_len    <= n_len;
                            r_min    <= n_min;
                            r_min_at <= n_min_at;
                            r_max    <= n_max;
                            r_max_at <= n_max_at;
                            r_ovf    <= n_ovf;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_roots_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_done == seg_done)
        else $error("root units out of step");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(MAX_POINTS)))
        else $error("overflow flag without saturated count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("minimum norm above maximum norm");

    a_commit_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) && $changed(r_state) |-> $past(norm_done))
        else $error("commit without finished root");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for path_norm_statistics. A table of directed elements
// is sent first, then random paths, then a short zigzag path between the two
// corner points. Every path summary is checked field by field against a
// behavioral model of the block or a hand-written expected summary. Both
// stream sides idle at random in the directed table and first two random phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pns_pkg::*;

    localparam int                PATH_CAP   = 4096;
    localparam longint unsigned   LENGTH_TOP = 64'h1F_FFFF_FFFF;
    localparam longint unsigned   MAG_INIT   = 64'h1FF_FFFF;
    localparam logic signed [23:0] C_MIN     = 24'sh800000;
    localparam logic signed [23:0] C_MAX     = 24'sh7FFFFF;
    localparam int                RAND_ITEMS = 600;    // per phase
    localparam int                DRAIN_CYC  = 40;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        bit                 last;
        bit                 typed;
        t_result            want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // coord_x, coord_y, coord_z
    logic                   s_axis_tlast;   // last_point
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // total_length, least_norm, least_pos, greatest_norm, greatest_pos,
    // point_total, too_many, zero fill
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    path_norm_statistics uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // path tracker state
    logic signed [23:0] last_x, last_y, last_z;
    int                 seen_cnt;
    longint unsigned    length_acc;
    longint unsigned    min_norm, max_norm;
    int                 min_idx, max_idx;
    bit                 over_cap;

    t_result pending_summaries[$];
    t_row    directed_rows[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    t_result got_sum, want_sum;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned rest, rt, probe;
        rest  = v;
        rt    = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0) begin
            if (rest >= rt + probe) begin
                rest -= rt + probe;
                rt = (rt >> 1) + probe;
            end else begin
                rt >>= 1;
            end
            probe >>= 2;
        end
        return rt;
    endfunction

    function automatic longint unsigned norm3(longint a, longint b, longint c);
        longint unsigned ua, ub, uc;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        uc = (c < 0) ? -c : c;
        return floor_root(ua * ua + ub * ub + uc * uc);
    endfunction

    function automatic void clear_path();
        last_x     = '0;
        last_y     = '0;
        last_z     = '0;
        seen_cnt   = 0;
        length_acc = 0;
        min_norm   = MAG_INIT;
        min_idx    = 0;
        max_norm   = 0;
        max_idx    = 0;
        over_cap   = 1'b0;
    endfunction

    // Fold one accepted element into the path; returns 1 when it closes a path.
    function automatic bit track_element(input logic signed [23:0] x, y, z,
                                         input bit last, output t_result res);
        longint unsigned seg, n;
        int              idx;
        res = '0;
        if (seen_cnt > 0) begin
            seg = norm3(longint'(x) - longint'(last_x), longint'(y) - longint'(last_y),
                        longint'(z) - longint'(last_z));
            length_acc += seg;
            if (length_acc > LENGTH_TOP)
                length_acc = LENGTH_TOP;
        end
        if (seen_cnt >= PATH_CAP) begin
            idx      = PATH_CAP - 1;
            over_cap = 1'b1;
        end else begin
            idx = seen_cnt;
            seen_cnt++;
        end
        n = norm3(longint'(x), longint'(y), longint'(z));
        if (n < min_norm) begin
            min_norm = n;
            min_idx  = idx;
        end
        if (n > max_norm) begin
            max_norm = n;
            max_idx  = idx;
        end
        last_x = x;
        last_y = y;
        last_z = z;
        if (!last)
            return 1'b0;
        res.total_length  = length_acc[LEN_W-1:0];
        res.least_norm    = min_norm[MAG_W-1:0];
        res.least_pos     = POS_W'(min_idx);
        res.greatest_norm = max_norm[MAG_W-1:0];
        res.greatest_pos  = POS_W'(max_idx);
        res.point_total   = TOT_W'(seen_cnt);
        res.too_many      = over_cap;
        clear_path();
        return 1'b1;
    endfunction

    function automatic t_result make_summary(longint unsigned len, int lnorm, int lpos,
                                             int gnorm, int gpos, int tot, bit over);
        t_result r;
        r.total_length  = LEN_W'(len);
        r.least_norm    = MAG_W'(lnorm);
        r.least_pos     = POS_W'(lpos);
        r.greatest_norm = MAG_W'(gnorm);
        r.greatest_pos  = POS_W'(gpos);
        r.point_total   = TOT_W'(tot);
        r.too_many      = over;
        return r;
    endfunction

    task automatic add_row(input logic signed [23:0] x, y, z, input bit last,
                           input bit typed, input t_result want);
        t_row r;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        directed_rows = {directed_rows, r};
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (error_count < 50)
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one element; the request completes at the edge where tready is seen high.
    task automatic push_element(input logic signed [23:0] x, y, z, input bit last,
                                input bit typed, input t_result want);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (track_element(x, y, z, last, res))
            pending_summaries = {pending_summaries, typed ? want : res};
    endtask

    function automatic logic signed [23:0] pick_coord(logic signed [23:0] prev);
        case ($urandom_range(5))
            0, 1: return 24'($urandom);
            2:    return prev + 24'($signed(8'($urandom)));   // short hop
            3: begin
                case ($urandom_range(2))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    default: return '0;
                endcase
            end
            default: return prev;                             // repeat, gives ties
        endcase
    endfunction

    // zigzag = 1 alternates the two corner points, giving the longest segments
    task automatic send_path(input int len, input bit zigzag);
        logic signed [23:0] x, y, z;
        x = '0;
        y = '0;
        z = '0;
        for (int i = 0; i < len; i++) begin
            if (zigzag) begin
                x = i[0] ? C_MAX : C_MIN;
                y = x;
                z = x;
            end else begin
                x = pick_coord(x);
                y = pick_coord(y);
                z = pick_coord(z);
            end
            push_element(x, y, z, i == len - 1, 1'b0, '0);
        end
    endtask

    // result side: check every completed request, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_sum = t_result'(m_axis_tdata[OUT_W-1:0]);
            if (pending_summaries.size() == 0) begin
                report_mismatch("unexpected summary", 1, 0);
            end else begin
                want_sum = pending_summaries.pop_front();
                if (got_sum.total_length !== want_sum.total_length)
                    report_mismatch("total_length", got_sum.total_length,
                                    want_sum.total_length);
                if (got_sum.least_norm !== want_sum.least_norm)
                    report_mismatch("least_norm", got_sum.least_norm, want_sum.least_norm);
                if (got_sum.least_pos !== want_sum.least_pos)
                    report_mismatch("least_pos", got_sum.least_pos, want_sum.least_pos);
                if (got_sum.greatest_norm !== want_sum.greatest_norm)
                    report_mismatch("greatest_norm", got_sum.greatest_norm,
                                    want_sum.greatest_norm);
                if (got_sum.greatest_pos !== want_sum.greatest_pos)
                    report_mismatch("greatest_pos", got_sum.greatest_pos,
                                    want_sum.greatest_pos);
                if (got_sum.point_total !== want_sum.point_total)
                    report_mismatch("point_total", got_sum.point_total,
                                    want_sum.point_total);
                if (got_sum.too_many !== want_sum.too_many)
                    report_mismatch("too_many", got_sum.too_many, want_sum.too_many);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        int sent;
        int len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        clear_path();

        // single elements: zero vector, 3-4-12 vector
        add_row(0, 0, 0, 1, 1, make_summary(0, 0, 0, 0, 0, 1, 0));
        add_row(3, 4, 12, 1, 1, make_summary(0, 13, 0, 13, 0, 1, 0));
        // first element adds no segment
        add_row(0, 0, 0, 0, 0, '0);
        add_row(3, 4, 0, 1, 1, make_summary(5, 0, 0, 5, 1, 2, 0));
        // equal norms keep the first index
        add_row(5, 0, 0, 0, 0, '0);
        add_row(0, 5, 0, 0, 0, '0);
        add_row(0, 0, -5, 1, 1, make_summary(14, 5, 0, 5, 0, 3, 0));
        // min and max move later in the path
        add_row(100, 0, 0, 0, 0, '0);
        add_row(50, 0, 0, 0, 0, '0);
        add_row(200, 0, 0, 1, 1, make_summary(200, 50, 1, 200, 2, 3, 0));
        // corner coordinates
        add_row(C_MIN, C_MIN, C_MIN, 1, 0, '0);
        add_row(C_MAX, C_MAX, C_MAX, 1, 0, '0);
        add_row(C_MIN, C_MIN, C_MIN, 0, 0, '0);
        add_row(C_MAX, C_MAX, C_MAX, 1, 0, '0);
        add_row(C_MAX, C_MIN, 0, 0, 0, '0);
        add_row(C_MIN, C_MAX, 1, 0, 0, '0);
        add_row(1, -1, C_MIN, 0, 0, '0);
        add_row(0, 0, 0, 1, 0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 52;
        foreach (directed_rows[i])
            push_element(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                         directed_rows[i].last, directed_rows[i].typed,
                         directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 34 : 0;
            sent = 0;
            while (sent < RAND_ITEMS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(12, 1);
                send_path(len, 1'b0);
                sent += len;
            end
        end

        // corner to corner, the longest segments
        send_path(24, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (pending_summaries.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
